>>> rtl/tba_pkg.sv
`timescale 1ns / 1ps

package tba_pkg;

  localparam int MAX_BLOCKS  = 128;
  localparam int TOTAL_TILES = 1024;
  localparam int KEY_BITS    = 32;

  localparam int NSLOT   = MAX_BLOCKS + 2;
  localparam int SLOT_W  = $clog2(NSLOT);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int ORD_AW  = $clog2(MAX_BLOCKS);
  localparam int TILE_W  = $clog2(TOTAL_TILES + 1);
  localparam int START_W = $clog2(TOTAL_TILES);
  localparam int USE_W   = 16;

  localparam logic [SLOT_W-1:0] HEAD = '0;
  localparam logic [SLOT_W-1:0] TAIL = SLOT_W'(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_USED = 2'd1,
    ST_PEND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    K_FIND   = 3'd0,
    K_CREATE = 3'd1,
    K_ALLOC  = 3'd2,
    K_ADD    = 3'd3,
    K_DROP   = 3'd4,
    K_SWEEP  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]          kind;
    logic [KEY_BITS-1:0] source_key;
    logic [10:0]         request_tiles;
    logic [1:0]          packing;
    logic [7:0]          target_block;
  } req_t;

  typedef struct packed {
    logic [7:0]  block_id;
    logic        ok;
    logic [9:0]  first_tile;
    logic [10:0] block_tiles;
    logic        write_now;
    logic [10:0] free_tiles;
    logic [7:0]  spare_slots;
  } res_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [START_W-1:0]  start;
    logic [TILE_W-1:0]   size;
    status_e             status;
    logic [1:0]          packing;
    logic [USE_W-1:0]    uses;
    logic [SLOT_W-1:0]   prev;
    logic [SLOT_W-1:0]   next;
  } slot_t;

endpackage

>>> rtl/tba_ram.sv
`timescale 1ns / 1ps

module tba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tile_block_allocator.sv
`timescale 1ns / 1ps

// Tile block allocator. A request beat is taken when start is high and busy
// is low; the block then stays busy until the result has been shown. Each
// request yields exactly one result beat, held on res_o for one cycle with
// done_o high; the receiver cannot stall it, so it must take every beat.
// Kinds: find, create, keyless allocate, add use, drop use and sweep.
// All block descriptors, the two size-sorted order lists and the spare slot
// stack live in single-port-per-direction memories with registered reads, and
// one sequencer walks them with a shared size compare. Latency depends on
// the work: a key lookup visits up to 128 slots in turn, every sorted-list
// search, insert or removal steps through the list entry by entry, and a
// sweep repeats a few such walks for each pending block. A simple add or
// drop use reads and writes one descriptor; a keyed create that misses
// first scans every slot for the key. One request is in flight at a time.
// After reset the block runs a clearing pass over the descriptor memory and
// spare slot stack with busy high, then accepts requests.
module tile_block_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  tba_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output tba_pkg::res_t res_o
);

  import tba_pkg::*;

  localparam int ST_W = 42;

  typedef enum logic [ST_W-1:0] {
    S_INIT     = 42'd1 << 0,
    S_IDLE     = 42'd1 << 1,
    S_DISP     = 42'd1 << 2,
    S_LK_RD    = 42'd1 << 3,
    S_LK_CHK   = 42'd1 << 4,
    S_AU       = 42'd1 << 5,
    S_UT_CHK   = 42'd1 << 6,
    S_CR_TOP   = 42'd1 << 7,
    S_CR_PEND  = 42'd1 << 8,
    S_FP       = 42'd1 << 9,
    S_FP_GOT   = 42'd1 << 10,
    S_FP_FAIL  = 42'd1 << 11,
    S_TK       = 42'd1 << 12,
    S_TK_POP   = 42'd1 << 13,
    S_TK_OWN   = 42'd1 << 14,
    S_TK_INS   = 42'd1 << 15,
    S_SW_START = 42'd1 << 16,
    S_SW_NEXT  = 42'd1 << 17,
    S_SW_ID    = 42'd1 << 18,
    S_SW_REC   = 42'd1 << 19,
    S_SW_NB    = 42'd1 << 20,
    S_SW_NBE   = 42'd1 << 21,
    S_SW_PV    = 42'd1 << 22,
    S_SW_PB    = 42'd1 << 23,
    S_SW_PBE   = 42'd1 << 24,
    S_SW_INS   = 42'd1 << 25,
    S_SW_STEP  = 42'd1 << 26,
    S_SW_END   = 42'd1 << 27,
    S_LN_RD    = 42'd1 << 28,
    S_LN_WR    = 42'd1 << 29,
    S_SC_RD    = 42'd1 << 30,
    S_SC_ID    = 42'd1 << 31,
    S_SC_SZ    = 42'd1 << 32,
    S_SC_END   = 42'd1 << 33,
    S_SH_RD    = 42'd1 << 34,
    S_SH_WR    = 42'd1 << 35,
    S_ER_RD    = 42'd1 << 36,
    S_ER_CMP   = 42'd1 << 37,
    S_RM_RD    = 42'd1 << 38,
    S_RM_WR    = 42'd1 << 39,
    S_FIN      = 42'd1 << 40,
    S_OUT      = 42'd1 << 41
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  req_t   cmd_q, cmd_d;
  slot_t  rec_q, rec_d;
  res_t   res_q, res_d;
  logic   done_q, done_d;

  logic [SLOT_W-1:0] id_q, id_d, cand_q, cand_d, split_q, split_d, cur_q, cur_d;
  logic [SLOT_W-1:0] mrg_q, mrg_d, ins_id_q, ins_id_d, ln_addr_q, ln_addr_d;
  logic [SLOT_W-1:0] ln_val_q, ln_val_d, lk_q, lk_d, init_q, init_d;
  logic [CNT_W-1:0]  pos_q, pos_d, j_q, j_d, sw_i_q, sw_i_d;
  logic [CNT_W-1:0]  free_cnt_q, free_cnt_d, pend_cnt_q, pend_cnt_d, stk_cnt_q, stk_cnt_d;
  logic [TILE_W-1:0] cmp_sz_q, cmp_sz_d, rest_q, rest_d;
  logic [TILE_W-1:0] free_tot_q, free_tot_d, pend_tot_q, pend_tot_d;
  logic ln_next_q, ln_next_d, lsel_q, lsel_d, le_q, le_d, ins_q, ins_d;
  logic found_q, found_d, wn_q, wn_d, ok_q, ok_d, retry_q, retry_d;
  logic pend_nz_q, pend_nz_d, defer_q, defer_d;

  // Memory ports.
  logic                  slot_we, slot_re;
  logic [SLOT_W-1:0]     slot_waddr, slot_raddr;
  slot_t                 slot_wdata, slot_rd;
  logic [$bits(slot_t)-1:0] slot_rdata;
  logic                  ord_we, ord_re;
  logic [ORD_AW:0]       ord_waddr, ord_raddr;
  logic [SLOT_W-1:0]     ord_wdata, ord_rdata;
  logic                  stk_we, stk_re;
  logic [ORD_AW-1:0]     stk_waddr, stk_raddr;
  logic [SLOT_W-1:0]     stk_wdata, stk_rdata;

  tba_ram #(.WIDTH($bits(slot_t)), .DEPTH(NSLOT)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  tba_ram #(.WIDTH(SLOT_W), .DEPTH(2 * MAX_BLOCKS)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  tba_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_BLOCKS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign slot_rd = slot_t'(slot_rdata);

  logic [CNT_W-1:0]    lcnt, pos_inc, stk_dec;
  logic [KEY_BITS-1:0] eff_key;
  logic [1:0]          eff_pk;
  slot_t               clr_rec, take_rec;

  assign lcnt    = lsel_q ? pend_cnt_q : free_cnt_q;
  assign pos_inc = pos_q + CNT_W'(1);
  assign stk_dec = stk_cnt_q - CNT_W'(1);
  assign eff_key = (cmd_q.kind == K_ALLOC) ? '0 : cmd_q.source_key;
  assign eff_pk  = (cmd_q.kind == K_ALLOC) ? '0 : cmd_q.packing;

  always_comb begin
    clr_rec        = '0;
    clr_rec.status = ST_FREE;
    clr_rec.prev   = TAIL;
    clr_rec.next   = TAIL;
    take_rec         = rec_q;
    take_rec.key     = eff_key;
    take_rec.packing = eff_pk;
    take_rec.size    = cmd_q.request_tiles;
    take_rec.uses    = USE_W'(1);
    take_rec.status  = ST_USED;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  always_comb begin
    state_d = state_q; ret_d = ret_q; cmd_d = cmd_q; rec_d = rec_q;
    res_d = res_q; done_d = 1'b0;
    id_d = id_q; cand_d = cand_q; split_d = split_q; cur_d = cur_q; mrg_d = mrg_q;
    ins_id_d = ins_id_q; ln_addr_d = ln_addr_q; ln_val_d = ln_val_q; lk_d = lk_q;
    init_d = init_q; pos_d = pos_q; j_d = j_q; sw_i_d = sw_i_q;
    free_cnt_d = free_cnt_q; pend_cnt_d = pend_cnt_q; stk_cnt_d = stk_cnt_q;
    cmp_sz_d = cmp_sz_q; rest_d = rest_q; free_tot_d = free_tot_q; pend_tot_d = pend_tot_q;
    ln_next_d = ln_next_q; lsel_d = lsel_q; le_d = le_q; ins_d = ins_q;
    found_d = found_q; wn_d = wn_q; ok_d = ok_q; retry_d = retry_q;
    pend_nz_d = pend_nz_q; defer_d = defer_q;

    slot_we = 1'b0; slot_waddr = '0; slot_wdata = clr_rec; slot_re = 1'b0; slot_raddr = '0;
    ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_re = 1'b0; ord_raddr = '0;
    stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_re = 1'b0; stk_raddr = '0;

    unique case (state_q)
      S_INIT: begin
        // Clearing pass: every descriptor, the spare stack, and the first free entry.
        slot_we    = 1'b1;
        slot_waddr = init_q;
        slot_wdata = clr_rec;
        if (init_q == HEAD) begin
          slot_wdata.next = SLOT_W'(1);
        end else if (init_q == SLOT_W'(1)) begin
          slot_wdata.prev = HEAD;
          slot_wdata.size = TILE_W'(TOTAL_TILES);
        end else if (init_q == TAIL) begin
          slot_wdata.prev = SLOT_W'(1);
        end
        if (init_q < SLOT_W'(MAX_BLOCKS)) begin
          stk_we    = 1'b1;
          stk_waddr = init_q[ORD_AW-1:0];
          stk_wdata = SLOT_W'(MAX_BLOCKS) - init_q;
        end
        if (init_q == HEAD) begin
          ord_we    = 1'b1;
          ord_waddr = '0;
          ord_wdata = SLOT_W'(1);
        end
        if (init_q == TAIL) begin
          state_d = S_IDLE;
        end else begin
          init_d = init_q + SLOT_W'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          cmd_d   = req_i;
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        id_d = '0; wn_d = 1'b0; ok_d = 1'b0; retry_d = 1'b0;
        lk_d = SLOT_W'(1);
        state_d = S_FIN;
        unique case (cmd_q.kind)
          K_FIND: begin
            if (cmd_q.source_key != '0) state_d = S_LK_RD;
          end
          K_CREATE: begin
            if (cmd_q.request_tiles != '0) begin
              state_d = (cmd_q.source_key != '0) ? S_LK_RD : S_CR_TOP;
            end
          end
          K_ALLOC: begin
            if (cmd_q.request_tiles != '0 && !defer_q) state_d = S_FP;
          end
          K_ADD, K_DROP: begin
            if (cmd_q.target_block != '0 &&
                cmd_q.target_block <= 8'(MAX_BLOCKS)) begin
              slot_re    = 1'b1;
              slot_raddr = SLOT_W'(cmd_q.target_block);
              state_d    = S_UT_CHK;
            end
          end
          K_SWEEP: begin
            ok_d    = 1'b1;
            state_d = S_SW_START;
          end
          default: state_d = S_FIN;
        endcase
      end

      S_LK_RD: begin
        slot_re    = 1'b1;
        slot_raddr = lk_q;
        state_d    = S_LK_CHK;
      end

      S_LK_CHK: begin
        if (slot_rd.status != ST_FREE && slot_rd.key == cmd_q.source_key) begin
          id_d    = lk_q;
          rec_d   = slot_rd;
          state_d = S_AU;
        end else if (lk_q == SLOT_W'(MAX_BLOCKS)) begin
          state_d = (cmd_q.kind == K_FIND) ? S_FIN : S_CR_TOP;
        end else begin
          lk_d    = lk_q + SLOT_W'(1);
          state_d = S_LK_RD;
        end
      end

      S_AU: begin
        slot_we    = 1'b1;
        slot_waddr = id_q;
        slot_wdata = rec_q;
        if (rec_q.status == ST_USED) begin
          if (rec_q.uses != '1) slot_wdata.uses = rec_q.uses + USE_W'(1);
          state_d = S_FIN;
        end else begin
          // Revive a pending block and take it off the pending list.
          slot_wdata.uses   = USE_W'(1);
          slot_wdata.status = ST_USED;
          pend_tot_d = pend_tot_q - rec_q.size;
          lsel_d = 1'b1; ins_id_d = id_q; pos_d = '0;
          ret_d = S_FIN; state_d = S_ER_RD;
        end
      end

      S_UT_CHK: begin
        state_d = S_FIN;
        if (slot_rd.status == ST_USED) begin
          id_d       = SLOT_W'(cmd_q.target_block);
          slot_we    = 1'b1;
          slot_waddr = SLOT_W'(cmd_q.target_block);
          slot_wdata = slot_rd;
          if (cmd_q.kind == K_ADD) begin
            if (slot_rd.uses != '1) slot_wdata.uses = slot_rd.uses + USE_W'(1);
          end else begin
            slot_wdata.uses = slot_rd.uses - USE_W'(1);
            if (slot_rd.uses == USE_W'(1)) begin
              slot_wdata.status = ST_PEND;
              pend_tot_d = pend_tot_q + slot_rd.size;
              lsel_d = 1'b1; ins_id_d = SLOT_W'(cmd_q.target_block);
              cmp_sz_d = slot_rd.size; le_d = 1'b1; ins_d = 1'b1; pos_d = '0;
              ret_d = S_FIN; state_d = S_SC_RD;
            end
          end
        end
      end

      S_CR_TOP: begin
        pend_nz_d = (pend_tot_q != '0);
        if (cmd_q.request_tiles <= pend_tot_q && (defer_q || cmd_q.packing == '0)) begin
          lsel_d = 1'b1; cmp_sz_d = cmd_q.request_tiles; le_d = 1'b0; ins_d = 1'b0;
          pos_d = '0; ret_d = S_CR_PEND; state_d = S_SC_RD;
        end else begin
          state_d = S_FP;
        end
      end

      S_CR_PEND: begin
        if (found_q && rec_q.size == cmd_q.request_tiles) begin
          // Exact-size pending block: reuse it in place, writes deferred.
          id_d       = cand_q;
          wn_d       = 1'b0;
          slot_we    = 1'b1;
          slot_waddr = cand_q;
          slot_wdata = take_rec;
          pend_tot_d = pend_tot_q - cmd_q.request_tiles;
          lsel_d = 1'b1; ret_d = S_FIN; state_d = S_RM_RD;
        end else begin
          state_d = S_FP;
        end
      end

      S_FP: begin
        if (cmd_q.request_tiles > free_tot_q) begin
          state_d = S_FP_FAIL;
        end else begin
          lsel_d = 1'b0; cmp_sz_d = cmd_q.request_tiles; le_d = 1'b0; ins_d = 1'b0;
          pos_d = '0; ret_d = S_FP_GOT; state_d = S_SC_RD;
        end
      end

      S_FP_GOT: begin
        if (!found_q || (rec_q.size > cmd_q.request_tiles && stk_cnt_q == '0)) begin
          state_d = S_FP_FAIL;
        end else begin
          id_d       = cand_q;
          rest_d     = rec_q.size - cmd_q.request_tiles;
          wn_d       = (eff_key != '0) && !(cmd_q.kind == K_CREATE && defer_q);
          free_tot_d = free_tot_q - cmd_q.request_tiles;
          lsel_d = 1'b0; ret_d = S_TK; state_d = S_RM_RD;
        end
      end

      S_FP_FAIL: begin
        if (cmd_q.kind == K_CREATE && pend_nz_q) begin
          retry_d = 1'b1;
          state_d = S_SW_START;
        end else begin
          state_d = S_FIN;
        end
      end

      S_TK: begin
        if (rest_q == '0 || stk_cnt_q == '0) begin
          slot_we    = 1'b1;
          slot_waddr = id_q;
          slot_wdata = take_rec;
          state_d    = S_FIN;
        end else begin
          stk_re    = 1'b1;
          stk_raddr = stk_dec[ORD_AW-1:0];
          stk_cnt_d = stk_dec;
          state_d   = S_TK_POP;
        end
      end

      S_TK_POP: begin
        split_d          = stk_rdata;
        slot_we          = 1'b1;
        slot_waddr       = stk_rdata;
        slot_wdata       = clr_rec;
        slot_wdata.prev  = id_q;
        slot_wdata.next  = rec_q.next;
        slot_wdata.start = rec_q.start + cmd_q.request_tiles[START_W-1:0];
        slot_wdata.size  = rest_q;
        state_d          = S_TK_OWN;
      end

      S_TK_OWN: begin
        slot_we         = 1'b1;
        slot_waddr      = id_q;
        slot_wdata      = take_rec;
        slot_wdata.next = split_q;
        ln_addr_d = rec_q.next; ln_val_d = split_q; ln_next_d = 1'b0;
        ret_d = S_TK_INS; state_d = S_LN_RD;
      end

      S_TK_INS: begin
        lsel_d = 1'b0; ins_id_d = split_q; cmp_sz_d = rest_q; le_d = 1'b1; ins_d = 1'b1;
        pos_d = '0; ret_d = S_FIN; state_d = S_SC_RD;
      end

      S_SW_START: begin
        sw_i_d  = '0;
        state_d = (pend_tot_q != '0) ? S_SW_NEXT : S_SW_END;
      end

      S_SW_NEXT: begin
        if (sw_i_q >= pend_cnt_q) begin
          pend_cnt_d = '0;
          pend_tot_d = '0;
          state_d    = S_SW_END;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = {1'b1, sw_i_q[ORD_AW-1:0]};
          state_d   = S_SW_ID;
        end
      end

      S_SW_ID: begin
        cur_d      = ord_rdata;
        slot_re    = 1'b1;
        slot_raddr = ord_rdata;
        state_d    = S_SW_REC;
      end

      S_SW_REC: begin
        rec_d        = slot_rd;
        rec_d.key    = '0;
        rec_d.status = ST_FREE;
        rec_d.uses   = '0;
        free_tot_d   = free_tot_q + slot_rd.size;
        if (slot_rd.next != TAIL) begin
          slot_re    = 1'b1;
          slot_raddr = slot_rd.next;
          state_d    = S_SW_NB;
        end else begin
          state_d = S_SW_PV;
        end
      end

      S_SW_NB: begin
        if (slot_rd.status == ST_FREE) begin
          // Absorb the free block that follows.
          mrg_d      = rec_q.next;
          rec_d.size = rec_q.size + slot_rd.size;
          rec_d.next = slot_rd.next;
          ln_addr_d = slot_rd.next; ln_val_d = cur_q; ln_next_d = 1'b0;
          ret_d = S_SW_NBE; state_d = S_LN_RD;
        end else begin
          state_d = S_SW_PV;
        end
      end

      S_SW_NBE, S_SW_PBE: begin
        slot_we    = 1'b1;
        slot_waddr = mrg_q;
        slot_wdata = clr_rec;
        if (stk_cnt_q < CNT_W'(MAX_BLOCKS)) begin
          stk_we    = 1'b1;
          stk_waddr = stk_cnt_q[ORD_AW-1:0];
          stk_wdata = mrg_q;
          stk_cnt_d = stk_cnt_q + CNT_W'(1);
        end
        lsel_d = 1'b0; ins_id_d = mrg_q; pos_d = '0;
        ret_d   = (state_q == S_SW_NBE) ? S_SW_PV : S_SW_INS;
        state_d = S_ER_RD;
      end

      S_SW_PV: begin
        if (rec_q.prev != HEAD) begin
          slot_re    = 1'b1;
          slot_raddr = rec_q.prev;
          state_d    = S_SW_PB;
        end else begin
          state_d = S_SW_INS;
        end
      end

      S_SW_PB: begin
        if (slot_rd.status == ST_FREE) begin
          // Absorb the free block in front; it donates its start tile.
          mrg_d       = rec_q.prev;
          rec_d.start = slot_rd.start;
          rec_d.size  = rec_q.size + slot_rd.size;
          rec_d.prev  = slot_rd.prev;
          ln_addr_d = slot_rd.prev; ln_val_d = cur_q; ln_next_d = 1'b1;
          ret_d = S_SW_PBE; state_d = S_LN_RD;
        end else begin
          state_d = S_SW_INS;
        end
      end

      S_SW_INS: begin
        slot_we    = 1'b1;
        slot_waddr = cur_q;
        slot_wdata = rec_q;
        lsel_d = 1'b0; ins_id_d = cur_q; cmp_sz_d = rec_q.size; le_d = 1'b1; ins_d = 1'b1;
        pos_d = '0; ret_d = S_SW_STEP; state_d = S_SC_RD;
      end

      S_SW_STEP: begin
        sw_i_d  = sw_i_q + CNT_W'(1);
        state_d = S_SW_NEXT;
      end

      S_SW_END: begin
        retry_d = 1'b0;
        defer_d = retry_q;
        state_d = retry_q ? S_CR_TOP : S_FIN;
      end

      S_LN_RD: begin
        slot_re    = 1'b1;
        slot_raddr = ln_addr_q;
        state_d    = S_LN_WR;
      end

      S_LN_WR: begin
        slot_we    = 1'b1;
        slot_waddr = ln_addr_q;
        slot_wdata = slot_rd;
        if (ln_next_q) slot_wdata.next = ln_val_q;
        else           slot_wdata.prev = ln_val_q;
        state_d = ret_q;
      end

      // Size scan of the selected list: stops at the first entry whose size
      // is not below (or, for an insert, not at or below) the compare size.
      S_SC_RD: begin
        if (pos_q >= lcnt) begin
          found_d = 1'b0;
          state_d = S_SC_END;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = {lsel_q, pos_q[ORD_AW-1:0]};
          state_d   = S_SC_ID;
        end
      end

      S_SC_ID: begin
        cand_d     = ord_rdata;
        slot_re    = 1'b1;
        slot_raddr = ord_rdata;
        state_d    = S_SC_SZ;
      end

      S_SC_SZ: begin
        if (le_q ? (slot_rd.size <= cmp_sz_q) : (slot_rd.size < cmp_sz_q)) begin
          pos_d   = pos_inc;
          state_d = S_SC_RD;
        end else begin
          found_d = 1'b1;
          rec_d   = slot_rd;
          state_d = S_SC_END;
        end
      end

      S_SC_END: begin
        j_d = lcnt;
        if (ins_q && lcnt < CNT_W'(MAX_BLOCKS)) state_d = S_SH_RD;
        else                                    state_d = ret_q;
      end

      S_SH_RD: begin
        if (j_q == pos_q) begin
          ord_we    = 1'b1;
          ord_waddr = {lsel_q, pos_q[ORD_AW-1:0]};
          ord_wdata = ins_id_q;
          if (lsel_q) pend_cnt_d = pend_cnt_q + CNT_W'(1);
          else        free_cnt_d = free_cnt_q + CNT_W'(1);
          state_d = ret_q;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = {lsel_q, ORD_AW'(j_q - CNT_W'(1))};
          state_d   = S_SH_WR;
        end
      end

      S_SH_WR: begin
        ord_we    = 1'b1;
        ord_waddr = {lsel_q, j_q[ORD_AW-1:0]};
        ord_wdata = ord_rdata;
        j_d       = j_q - CNT_W'(1);
        state_d   = S_SH_RD;
      end

      S_ER_RD: begin
        if (pos_q >= lcnt) begin
          state_d = ret_q;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = {lsel_q, pos_q[ORD_AW-1:0]};
          state_d   = S_ER_CMP;
        end
      end

      S_ER_CMP: begin
        if (ord_rdata == ins_id_q) begin
          state_d = S_RM_RD;
        end else begin
          pos_d   = pos_inc;
          state_d = S_ER_RD;
        end
      end

      // Close the gap at pos by moving every later entry down by one.
      S_RM_RD: begin
        if (pos_inc >= lcnt) begin
          if (lsel_q) pend_cnt_d = pend_cnt_q - CNT_W'(1);
          else        free_cnt_d = free_cnt_q - CNT_W'(1);
          state_d = ret_q;
        end else begin
          ord_re    = 1'b1;
          ord_raddr = {lsel_q, pos_inc[ORD_AW-1:0]};
          state_d   = S_RM_WR;
        end
      end

      S_RM_WR: begin
        ord_we    = 1'b1;
        ord_waddr = {lsel_q, pos_q[ORD_AW-1:0]};
        ord_wdata = ord_rdata;
        pos_d     = pos_inc;
        state_d   = S_RM_RD;
      end

      S_FIN: begin
        slot_re    = (id_q != '0);
        slot_raddr = id_q;
        state_d    = S_OUT;
      end

      S_OUT: begin
        done_d            = 1'b1;
        res_d.block_id    = id_q;
        res_d.ok          = ok_q || (id_q != '0);
        res_d.first_tile  = (id_q != '0) ? slot_rd.start : '0;
        res_d.block_tiles = (id_q != '0) ? slot_rd.size : '0;
        res_d.write_now   = wn_q;
        res_d.free_tiles  = free_tot_q;
        res_d.spare_slots = stk_cnt_q;
        state_d           = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; ret_q <= S_IDLE; done_q <= 1'b0;
      id_q <= '0; cand_q <= '0; split_q <= '0; cur_q <= '0; mrg_q <= '0;
      ins_id_q <= '0; ln_addr_q <= '0; ln_val_q <= '0; lk_q <= '0; init_q <= '0;
      pos_q <= '0; j_q <= '0; sw_i_q <= '0;
      free_cnt_q <= CNT_W'(1); pend_cnt_q <= '0; stk_cnt_q <= CNT_W'(MAX_BLOCKS - 1);
      cmp_sz_q <= '0; rest_q <= '0;
      free_tot_q <= TILE_W'(TOTAL_TILES); pend_tot_q <= '0;
      ln_next_q <= 1'b0; lsel_q <= 1'b0; le_q <= 1'b0; ins_q <= 1'b0;
      found_q <= 1'b0; wn_q <= 1'b0; ok_q <= 1'b0; retry_q <= 1'b0;
      pend_nz_q <= 1'b0; defer_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; done_q <= done_d;
      id_q <= id_d; cand_q <= cand_d; split_q <= split_d; cur_q <= cur_d; mrg_q <= mrg_d;
      ins_id_q <= ins_id_d; ln_addr_q <= ln_addr_d; ln_val_q <= ln_val_d;
      lk_q <= lk_d; init_q <= init_d;
      pos_q <= pos_d; j_q <= j_d; sw_i_q <= sw_i_d;
      free_cnt_q <= free_cnt_d; pend_cnt_q <= pend_cnt_d; stk_cnt_q <= stk_cnt_d;
      cmp_sz_q <= cmp_sz_d; rest_q <= rest_d;
      free_tot_q <= free_tot_d; pend_tot_q <= pend_tot_d;
      ln_next_q <= ln_next_d; lsel_q <= lsel_d; le_q <= le_d; ins_q <= ins_d;
      found_q <= found_d; wn_q <= wn_d; ok_q <= ok_d; retry_q <= retry_d;
      pend_nz_q <= pend_nz_d; defer_q <= defer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rec_q <= rec_d;
    res_q <= res_d;
  end

endmodule

>>> tb/tb_tile_block_allocator.sv
`timescale 1ns / 1ps

module tb_tile_block_allocator;
  import tba_pkg::*;

  localparam int IDLE_LIMIT = 600000;
  localparam int N_RANDOM   = 1620;
  localparam int CALM_TAIL  = 200;

  // Tracks the allocator's block table and predicts the grant of every request.
  class alloc_scoreboard;
    logic [KEY_BITS-1:0] blk_key[NSLOT];
    int unsigned blk_start[NSLOT];
    int unsigned blk_size[NSLOT];
    status_e     blk_stat[NSLOT];
    logic [1:0]  blk_pack[NSLOT];
    int unsigned blk_uses[NSLOT];
    int unsigned blk_prev[NSLOT];
    int unsigned blk_next[NSLOT];
    int unsigned free_list[$];
    int unsigned pend_list[$];
    int unsigned spare[$];
    int unsigned free_total;
    int unsigned pend_total;
    bit          deferred;
    res_t        expected_grants[$];
    int          mismatches;
    int          results_seen;
    int          grants_ok;

    function void clear_slot(int unsigned s);
      blk_key[s] = '0; blk_start[s] = 0; blk_size[s] = 0; blk_stat[s] = ST_FREE;
      blk_pack[s] = '0; blk_uses[s] = 0; blk_prev[s] = TAIL; blk_next[s] = TAIL;
    endfunction

    function void reset_table();
      int unsigned s;
      for (int i = 0; i < NSLOT; i++) clear_slot(i);
      blk_next[HEAD] = TAIL;
      blk_prev[TAIL] = HEAD;
      spare.delete();
      for (int i = 0; i < MAX_BLOCKS; i++) spare.push_back(MAX_BLOCKS - i);
      free_list.delete();
      pend_list.delete();
      s = insert_after(HEAD);
      blk_size[s] = TOTAL_TILES;
      free_list.push_back(s);
      free_total = TOTAL_TILES;
      pend_total = 0;
      deferred = 0;
      expected_grants.delete();
    endfunction

    function int unsigned lower_pos(int unsigned lst[$], int unsigned n);
      int unsigned p;
      p = 0;
      while (p < lst.size() && blk_size[lst[p]] < n) p++;
      return p;
    endfunction

    function void sorted_insert(ref int unsigned lst[$], input int unsigned id);
      int unsigned p;
      p = 0;
      if (lst.size() >= MAX_BLOCKS) return;
      while (p < lst.size() && blk_size[lst[p]] <= blk_size[id]) p++;
      lst.insert(p, id);
    endfunction

    function void sorted_erase(ref int unsigned lst[$], input int unsigned id);
      foreach (lst[i]) begin
        if (lst[i] == id) begin
          lst.delete(i);
          return;
        end
      end
    endfunction

    function void node_erase(int unsigned s);
      blk_next[blk_prev[s]] = blk_next[s];
      blk_prev[blk_next[s]] = blk_prev[s];
      clear_slot(s);
      if (spare.size() < MAX_BLOCKS) spare.push_back(s);
    endfunction

    function int unsigned insert_after(int unsigned pos);
      int unsigned s, n;
      if (spare.size() == 0) return 0;
      s = spare.pop_back();
      n = blk_next[pos];
      clear_slot(s);
      blk_prev[s] = pos; blk_next[s] = n;
      blk_next[pos] = s; blk_prev[n] = s;
      return s;
    endfunction

    function int unsigned take_block(int unsigned id, logic [KEY_BITS-1:0] k,
                                     logic [1:0] pk, int unsigned n);
      int unsigned rest, s;
      rest = blk_size[id] - n;
      s = 0;
      if (blk_stat[id] == ST_FREE) free_total -= n;
      else pend_total -= n;
      blk_key[id] = k; blk_pack[id] = pk; blk_size[id] = n;
      blk_uses[id] = 1; blk_stat[id] = ST_USED;
      if (rest != 0) begin
        s = insert_after(id);
        if (s != 0) begin
          blk_start[s] = blk_start[id] + n;
          blk_size[s] = rest;
        end
      end
      return s;
    endfunction

    // Pending blocks become free and merge with free neighbours on both sides.
    function void sweep_pending();
      int unsigned id, nb, pb;
      if (pend_total != 0) begin
        foreach (pend_list[i]) begin
          id = pend_list[i];
          blk_key[id] = '0; blk_stat[id] = ST_FREE; blk_uses[id] = 0;
          free_total += blk_size[id];
          nb = blk_next[id];
          if (nb != TAIL && blk_stat[nb] == ST_FREE) begin
            blk_size[id] += blk_size[nb];
            sorted_erase(free_list, nb);
            node_erase(nb);
          end
          pb = blk_prev[id];
          if (pb != HEAD && blk_stat[pb] == ST_FREE) begin
            blk_start[id] = blk_start[pb];
            blk_size[id] += blk_size[pb];
            sorted_erase(free_list, pb);
            node_erase(pb);
          end
          sorted_insert(free_list, id);
        end
        pend_list.delete();
        pend_total = 0;
      end
      deferred = 0;
    endfunction

    function int unsigned best_fit(logic [KEY_BITS-1:0] k, logic [1:0] pk, int unsigned n,
                                   bit defer_now, output bit wn);
      int unsigned p, id, s;
      wn = 0;
      if (n > free_total) return 0;
      p = lower_pos(free_list, n);
      if (p >= free_list.size()) return 0;
      id = free_list[p];
      if (blk_size[id] > n && spare.size() == 0) return 0;
      free_list.delete(p);
      s = take_block(id, k, pk, n);
      if (s != 0) sorted_insert(free_list, s);
      wn = (k != 0) && !defer_now;
      return id;
    endfunction

    function int unsigned create_block(logic [KEY_BITS-1:0] k, logic [1:0] pk,
                                       int unsigned n, output bit wn);
      int unsigned pend, id, p;
      wn = 0;
      forever begin
        pend = pend_total;
        if (n <= pend && (deferred || pk == 0)) begin
          p = lower_pos(pend_list, n);
          if (p < pend_list.size() && blk_size[pend_list[p]] == n) begin
            id = pend_list[p];
            pend_list.delete(p);
            void'(take_block(id, k, pk, n));
            wn = 0;
            return id;
          end
        end
        id = best_fit(k, pk, n, deferred, wn);
        if (id != 0) return id;
        if (pend == 0) return 0;
        sweep_pending();
        deferred = 1;
      end
      return 0;
    endfunction

    function int unsigned key_slot(logic [KEY_BITS-1:0] k);
      if (k == 0) return 0;
      for (int unsigned s = 1; s <= MAX_BLOCKS; s++)
        if (blk_stat[s] != ST_FREE && blk_key[s] == k) return s;
      return 0;
    endfunction

    function void revive_or_add(int unsigned id);
      if (blk_stat[id] == ST_USED) begin
        if (blk_uses[id] < 16'hFFFF) blk_uses[id]++;
      end else begin
        blk_uses[id] = 1;
        blk_stat[id] = ST_USED;
        sorted_erase(pend_list, id);
        pend_total -= blk_size[id];
      end
    endfunction

    function res_t predict_grant(req_t r);
      res_t g;
      int unsigned id, n, tgt;
      bit ok, wn;
      id = 0; ok = 0; wn = 0;
      n = r.request_tiles;
      tgt = r.target_block;
      case (r.kind)
        K_FIND: begin
          id = key_slot(r.source_key);
          if (id != 0) revive_or_add(id);
        end
        K_CREATE: begin
          if (n != 0) begin
            id = key_slot(r.source_key);
            if (id != 0) revive_or_add(id);
            else id = create_block(r.source_key, r.packing, n, wn);
          end
        end
        K_ALLOC: begin
          if (n != 0 && !deferred) id = best_fit('0, 2'd0, n, 1'b0, wn);
        end
        K_ADD, K_DROP: begin
          if (tgt != 0 && tgt <= MAX_BLOCKS && blk_stat[tgt] == ST_USED) begin
            id = tgt;
            if (r.kind == K_ADD) begin
              if (blk_uses[id] < 16'hFFFF) blk_uses[id]++;
            end else begin
              blk_uses[id]--;
              if (blk_uses[id] == 0) begin
                blk_stat[id] = ST_PEND;
                sorted_insert(pend_list, id);
                pend_total += blk_size[id];
              end
            end
          end
        end
        K_SWEEP: begin
          sweep_pending();
          ok = 1;
        end
        default: ;
      endcase
      if (id != 0) ok = 1;
      g.block_id    = id[7:0];
      g.ok          = ok;
      g.first_tile  = (id != 0) ? blk_start[id][9:0] : '0;
      g.block_tiles = (id != 0) ? blk_size[id][10:0] : '0;
      g.write_now   = wn;
      g.free_tiles  = free_total[10:0];
      g.spare_slots = spare.size();
      return g;
    endfunction

    function void note_request(req_t r);
      expected_grants.push_back(predict_grant(r));
    endfunction

    function void check_grant(res_t got);
      res_t exp_g;
      results_seen++;
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      exp_g = expected_grants.pop_front();
      if (exp_g.ok) grants_ok++;
      if (got.block_id !== exp_g.block_id || got.ok !== exp_g.ok ||
          got.first_tile !== exp_g.first_tile || got.block_tiles !== exp_g.block_tiles ||
          got.write_now !== exp_g.write_now || got.free_tiles !== exp_g.free_tiles ||
          got.spare_slots !== exp_g.spare_slots) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: expected %p, got %p", results_seen, exp_g, got);
      end
    endfunction

    function int unsigned pick_used();
      int unsigned used[$];
      for (int unsigned s = 1; s <= MAX_BLOCKS; s++)
        if (blk_stat[s] == ST_USED) used.push_back(s);
      if (used.size() == 0) return 0;
      return used[$urandom_range(used.size() - 1)];
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic done_o;
  res_t res_o;

  alloc_scoreboard sb = new();
  logic [KEY_BITS-1:0] key_pool[24];
  int idle_cycles = 0;
  int kind_hits[8];
  bit allow_gaps = 1'b1;

  always #1 clk_i = ~clk_i;

  tile_block_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_grant(res_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("FAIL tile_block_allocator");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The beat is taken at the first edge that sees busy low with start high.
  task automatic send(req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    sb.note_request(r);
    kind_hits[r.kind]++;
    if (allow_gaps && $urandom_range(3) == 0) begin
      start <= 1'b0;
      req_i <= req_t'({$urandom, $urandom});
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  function automatic req_t make_req(kind_e k, logic [KEY_BITS-1:0] key, int unsigned n,
                                    logic [1:0] pk, int unsigned tgt);
    req_t r;
    r.kind = k;
    r.source_key = key;
    r.request_tiles = n[10:0];
    r.packing = pk;
    r.target_block = tgt[7:0];
    return r;
  endfunction

  function automatic int unsigned rand_tiles();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 2) return $urandom_range(1) ? 0 : $urandom_range(1025, 2047);
    if (p < 70) return $urandom_range(1, 32);
    if (p < 95) return $urandom_range(33, 200);
    return $urandom_range(201, 1024);
  endfunction

  function automatic logic [KEY_BITS-1:0] rand_key();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 8) return '0;
    if (p < 15) return $urandom;
    return key_pool[$urandom_range(23)];
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int unsigned p, tgt;
    r = req_t'({$urandom, $urandom});
    p = $urandom_range(99);
    tgt = ($urandom_range(99) < 85) ? sb.pick_used() : $urandom_range(255);
    if (p < 32)      r = make_req(K_CREATE, rand_key(), rand_tiles(), r.packing, r.target_block);
    else if (p < 42) r = make_req(K_FIND, rand_key(), r.request_tiles, r.packing, r.target_block);
    else if (p < 52) r = make_req(K_ALLOC, r.source_key, rand_tiles(), r.packing, r.target_block);
    else if (p < 62) r = make_req(K_ADD, r.source_key, r.request_tiles, r.packing, tgt);
    else if (p < 92) r = make_req(K_DROP, r.source_key, r.request_tiles, r.packing, tgt);
    else if (p < 97) r.kind = K_SWEEP;
    else             r.kind = 3'($urandom_range(6, 7));
    return r;
  endfunction

  initial begin
    logic [KEY_BITS-1:0] ka, kb, kx, ky;
    int unsigned id;
    foreach (key_pool[i]) key_pool[i] = $urandom | 32'h1;
    key_pool[0] = '1;
    ka = key_pool[1]; kb = key_pool[2]; kx = key_pool[3]; ky = key_pool[4];
    sb.reset_table();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: zero key, bad sizes, key hits, pending reuse, deferral.
    send(make_req(K_FIND, '0, 1, 0, 0));
    send(make_req(K_CREATE, ka, 0, 0, 0));
    send(make_req(K_CREATE, ka, 1, 0, 0));
    send(make_req(K_CREATE, ka, 5, 3, 0));
    send(make_req(K_FIND, ka, 1, 0, 0));
    send(make_req(K_CREATE, '0, 10, 2, 0));
    send(make_req(K_ALLOC, '0, 1024, 0, 0));
    send(make_req(K_ALLOC, '1, 3, 3, 255));
    send(make_req(K_ADD, '0, 1, 0, 0));
    send(make_req(K_ADD, '0, 1, 0, 129));
    send(make_req(K_DROP, '0, 1, 0, 200));
    send(make_req(K_DROP, '0, 1, 0, 255));
    id = sb.key_slot(ka);
    repeat (3) send(make_req(K_DROP, '0, 1, 0, id));
    send(make_req(K_CREATE, kb, 1, 1, 0));
    send(make_req(K_CREATE, key_pool[5], 1, 0, 0));
    send(make_req(K_CREATE, kx, 900, 0, 0));
    send(make_req(K_DROP, '0, 1, 0, sb.key_slot(kx)));
    send(make_req(K_CREATE, ky, 950, 1, 0));
    send(make_req(K_ALLOC, '0, 4, 0, 0));
    send(make_req(K_SWEEP, '0, 2047, 3, 0));
    send(make_req(req_t'(6) >> 0 == 0 ? K_SWEEP : K_SWEEP, '0, 0, 0, 0));
    send(make_req(K_DROP, '0, 1, 0, sb.key_slot(ky)));
    send(make_req(K_CREATE, '1, 2047, 3, 0));
    begin
      req_t odd;
      odd = req_t'({$urandom, $urandom});
      odd.kind = 3'd7;
      send(odd);
      odd.kind = 3'd6;
      send(odd);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        // Hold off until the allocator has answered everything in flight.
        start <= 1'b0;
        while (sb.expected_grants.size() != 0) @(posedge clk_i);
      end
      if (i == N_RANDOM - CALM_TAIL) allow_gaps = 1'b0;
      send(rand_req());
    end
    start <= 1'b0;
    while (sb.expected_grants.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("Covered %0d results (%0d successful): creates %0d, finds %0d, allocs %0d,",
             sb.results_seen, sb.grants_ok, kind_hits[K_CREATE], kind_hits[K_FIND],
             kind_hits[K_ALLOC]);
    $display("add uses %0d, drop uses %0d, sweeps %0d, unknown kinds %0d; mismatches %0d.",
             kind_hits[K_ADD], kind_hits[K_DROP], kind_hits[K_SWEEP],
             kind_hits[6] + kind_hits[7], sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_grants.size() == 0) begin
      $display("PASS tile_block_allocator");
    end else begin
      $display("FAIL tile_block_allocator");
    end
    $finish;
  end

endmodule
